/* hw/rtl/lcd_scanline_mode_timer_defines.svh */
// ----------------------------------------------------------------------------
// LCD scanline mode timer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with a
// synchronous active-low reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef LCD_SCANLINE_MODE_TIMER_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_DEFINES_SVH

// Same-cycle implication.
`define LSMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsmt: assertion failed");

// Next-cycle implication.
`define LSMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsmt: assertion failed");

`endif

/* hw/rtl/lsmt_pkg.sv */
// ----------------------------------------------------------------------------
// LCD scanline mode timer package
// Request and result types, timer state, mode and opcode codes, line and
// cycle constants.
// ----------------------------------------------------------------------------
package lsmt_pkg;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_LCDC    = 2'd1,
        OP_LYC     = 2'd2,
        OP_STAT    = 2'd3
    } lsmt_op_t;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SPRITE   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lsmt_mode_t;

    // stat enable bit positions
    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_SPRITE = 2;
    localparam int unsigned EN_COINC  = 3;

    localparam int unsigned LCDC_ON_BIT = 7;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] SHORT_LINE  = 8'd153;
    localparam logic [7:0] LINE_END    = 8'd154;
    localparam logic [7:0] FIRST_LINE  = 8'd1;

    localparam logic [8:0] LINE_CYCLES             = 9'd456;
    localparam logic [8:0] LINE_CYCLES_AFTER_SHORT = 9'd452;
    localparam logic [8:0] SHORT_LINE_CYCLES       = 9'd4;
    localparam logic [8:0] HBLANK_CYCLES           = 9'd204;
    localparam logic [8:0] SPRITE_CYCLES           = 9'd80;
    localparam logic [8:0] TRANSFER_CYCLES         = 9'd172;

    localparam logic signed [11:0] BUDGET_MIN = -12'sd1024;
    localparam logic signed [11:0] BUDGET_MAX = 12'sd1023;

    typedef struct packed {
        lsmt_op_t   op;
        logic [7:0] cycles;
        logic [7:0] value;
    } lsmt_in_t;

    typedef struct packed {
        logic [7:0] line;
        lsmt_mode_t mode;
        logic       coincidence;
        logic       lcd_on;
        logic       stat_irq;
        logic       vblank_irq;
        logic       draw_line;
        logic       hdma_step;
        logic       frame_wrap;
    } lsmt_out_t;

    typedef struct packed {
        logic              lcd_en;
        logic [7:0]        line;
        lsmt_mode_t        mode;
        logic              coinc;
        logic [7:0]        cmp;
        logic [3:0]        en;
        logic signed [10:0] budget;
    } lsmt_state_t;

endpackage

/* hw/rtl/lsmt_step.sv */
// ----------------------------------------------------------------------------
// LCD scanline mode timer update
// Applies one request to the timer state: budget update, single mode step,
// line compare and event flags. Pure combinational.
// ----------------------------------------------------------------------------
module lsmt_step (
    input  lsmt_pkg::lsmt_state_t cur,
    input  lsmt_pkg::lsmt_in_t    req,
    output lsmt_pkg::lsmt_state_t nxt,
    output lsmt_pkg::lsmt_out_t   res
);
    import lsmt_pkg::*;

    logic signed [11:0] sub_full;
    logic signed [10:0] budget_dec;
    logic signed [11:0] add_full;
    logic [8:0]         add_amt;
    logic [7:0]         line_inc;
    logic               do_cmp;
    logic               lcd_on_req;
    logic               stat_raise;
    logic               vblank_ev;
    logic               draw_ev;
    logic               hdma_ev;
    logic               wrap_ev;
    logic               line_eq;

    assign sub_full   = $signed({cur.budget[10], cur.budget}) - $signed({4'b0000, req.cycles});
    assign budget_dec = (sub_full < BUDGET_MIN) ? BUDGET_MIN[10:0] : sub_full[10:0];
    assign line_inc   = cur.line + 8'd1;
    assign lcd_on_req = req.value[LCDC_ON_BIT];

    always_comb begin
        nxt        = cur;
        add_amt    = '0;
        add_full   = '0;
        line_eq    = 1'b0;
        do_cmp     = 1'b0;
        stat_raise = 1'b0;
        vblank_ev  = 1'b0;
        draw_ev    = 1'b0;
        hdma_ev    = 1'b0;
        wrap_ev    = 1'b0;

        unique case (req.op)
            OP_ADVANCE: begin
                if (cur.lcd_en) begin
                    nxt.budget = budget_dec;
                    if (budget_dec <= 11'sd0) begin
                        unique case (cur.mode)
                            MODE_HBLANK: begin
                                nxt.line = line_inc;
                                do_cmp   = 1'b1;
                                hdma_ev  = 1'b1;
                                if (line_inc == VBLANK_LINE) begin
                                    nxt.mode   = MODE_VBLANK;
                                    stat_raise = cur.en[EN_VBLANK];
                                    vblank_ev  = 1'b1;
                                    add_amt    = LINE_CYCLES;
                                end else begin
                                    nxt.mode   = MODE_SPRITE;
                                    stat_raise = cur.en[EN_SPRITE];
                                    add_amt    = SPRITE_CYCLES;
                                end
                            end
                            MODE_VBLANK: begin
                                priority if (line_inc == SHORT_LINE) begin
                                    nxt.line = line_inc;
                                    add_amt  = SHORT_LINE_CYCLES;
                                    do_cmp   = 1'b1;
                                end else if (line_inc == LINE_END) begin
                                    nxt.line = '0;
                                    add_amt  = LINE_CYCLES_AFTER_SHORT;
                                    wrap_ev  = 1'b1;
                                    do_cmp   = 1'b1;
                                end else if (line_inc == FIRST_LINE) begin
                                    nxt.line   = '0;
                                    nxt.mode   = MODE_SPRITE;
                                    stat_raise = cur.en[EN_SPRITE];
                                    add_amt    = SPRITE_CYCLES;
                                end else begin
                                    nxt.line = line_inc;
                                    add_amt  = LINE_CYCLES;
                                    do_cmp   = 1'b1;
                                end
                            end
                            MODE_SPRITE: begin
                                nxt.mode = MODE_TRANSFER;
                                add_amt  = TRANSFER_CYCLES;
                            end
                            MODE_TRANSFER: begin
                                nxt.mode   = MODE_HBLANK;
                                stat_raise = cur.en[EN_HBLANK];
                                draw_ev    = 1'b1;
                                add_amt    = HBLANK_CYCLES;
                            end
                            default: begin
                                nxt.mode = cur.mode;
                            end
                        endcase
                        add_full   = $signed({budget_dec[10], budget_dec})
                                   + $signed({3'b000, add_amt});
                        nxt.budget = (add_full > BUDGET_MAX) ? BUDGET_MAX[10:0] : add_full[10:0];
                    end
                end
            end
            OP_LCDC: begin
                if (cur.lcd_en && !lcd_on_req) begin
                    nxt.line = '0;
                    nxt.mode = MODE_HBLANK;
                end else if (!cur.lcd_en && lcd_on_req) begin
                    nxt.budget = '0;
                    nxt.mode   = MODE_TRANSFER;
                    do_cmp     = 1'b1;
                end
                nxt.lcd_en = lcd_on_req;
            end
            OP_LYC: begin
                nxt.cmp = req.value;
            end
            OP_STAT: begin
                nxt.en = req.value[6:3];
            end
            default: begin
                nxt = cur;
            end
        endcase

        line_eq = (nxt.line == cur.cmp);
        if (do_cmp) begin
            nxt.coinc = line_eq;
            if (line_eq && cur.en[EN_COINC]) begin
                stat_raise = 1'b1;
            end
        end
    end

    always_comb begin
        res.line        = nxt.line;
        res.mode        = nxt.mode;
        res.coincidence = nxt.coinc;
        res.lcd_on      = nxt.lcd_en;
        res.stat_irq    = stat_raise;
        res.vblank_irq  = vblank_ev;
        res.draw_line   = draw_ev;
        res.hdma_step   = hdma_ev;
        res.frame_wrap  = wrap_ev;
    end

endmodule

/* hw/rtl/lcd_scanline_mode_timer.sv */
// ----------------------------------------------------------------------------
// LCD scanline mode timer
// Scanline, display mode and cycle budget tracker for a handheld LCD
// controller, one result per request.
// ----------------------------------------------------------------------------
// Sustains one request per clock unless m_ready stalls the output: a request
// is registered, applied to the timer state by the update logic, and its
// result is registered in the output register that drives m_valid. The state
// update is the loop that sets the rate. While a result waits on m_ready, the
// input register takes one more request and then s_ready drops.
`include "lcd_scanline_mode_timer_defines.svh"

module lcd_scanline_mode_timer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lsmt_pkg::lsmt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lsmt_pkg::lsmt_out_t m_data
);
    import lsmt_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    lsmt_in_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    lsmt_out_t   out_data_reg;
    lsmt_state_t state_reg;
    lsmt_state_t state_next;
    lsmt_out_t   step_res;
    logic        fire;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    lsmt_step u_step (
        .cur (state_reg),
        .req (in_data_reg),
        .nxt (state_next),
        .res (step_res)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= step_res;
        end
    end

    `LSMT_ASSERT_NOW(a_line_range, aclk, aresetn, 1'b1, state_reg.line <= SHORT_LINE)
    `LSMT_ASSERT_NOW(a_off_idle, aclk, aresetn, !state_reg.lcd_en,
        state_reg.line == 8'd0 && state_reg.mode == MODE_HBLANK)
    `LSMT_ASSERT_NOW(a_budget_cap, aclk, aresetn, 1'b1, state_reg.budget <= 11'sd456)
    `LSMT_ASSERT_NOW(a_wrap_line0, aclk, aresetn, out_valid_reg && out_data_reg.frame_wrap,
        out_data_reg.line == 8'd0)
    `LSMT_ASSERT_NOW(a_vblank_mode, aclk, aresetn, out_valid_reg && out_data_reg.vblank_irq,
        out_data_reg.mode == MODE_VBLANK)
    `LSMT_ASSERT_NEXT(a_req_hold, aclk, aresetn, in_valid_reg && !fire, in_valid_reg)

endmodule

/* verif/lcd_timing_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline mode timer checker
// Follows the line, mode, compare and cycle budget state from every accepted
// request, predicts the status result it causes and compares each returned
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_timing_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lsmt_pkg::lsmt_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lsmt_pkg::lsmt_out_t m_data,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  wraps,
    output int                  stat_irqs
);
    import lsmt_pkg::*;

    logic       lcd_en;
    logic [7:0] ly;
    lsmt_mode_t mode;
    logic       coinc;
    logic [7:0] lyc;
    logic [3:0] stat_en;
    int         budget;

    lsmt_out_t  status;
    lsmt_out_t  want;
    lsmt_out_t  status_due[$];

    task automatic report_mismatch(string msg);
        if (errors < 50) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] due);
        if (got !== due) begin
            report_mismatch($sformatf("result %0d: %s is %0h, predicted %0h",
                                      checked, name, got, due));
        end
    endtask

    function void add_budget(int delta);
        int sum;
        sum = budget + delta;
        if (sum < int'(BUDGET_MIN)) sum = int'(BUDGET_MIN);
        if (sum > int'(BUDGET_MAX)) sum = int'(BUDGET_MAX);
        budget = sum;
    endfunction

    function void stat_if(int unsigned pos);
        if (stat_en[pos]) status.stat_irq = 1'b1;
    endfunction

    function void compare_ly();
        coinc = (ly == lyc);
        if (coinc) stat_if(EN_COINC);
    endfunction

    function void enter_mode(lsmt_mode_t m);
        mode = m;
        case (m)
            MODE_HBLANK: begin
                stat_if(EN_HBLANK);
                add_budget(int'(HBLANK_CYCLES));
                status.draw_line = 1'b1;
            end
            MODE_VBLANK: begin
                stat_if(EN_VBLANK);
                status.vblank_irq = 1'b1;
                add_budget(int'(LINE_CYCLES));
            end
            MODE_SPRITE: begin
                stat_if(EN_SPRITE);
                add_budget(int'(SPRITE_CYCLES));
            end
            default: begin
                add_budget(int'(TRANSFER_CYCLES));
            end
        endcase
    endfunction

    function lsmt_out_t predict_status(lsmt_in_t req);
        status = '0;
        case (req.op)
            OP_ADVANCE: begin
                if (lcd_en) begin
                    add_budget(-int'(req.cycles));
                    if (budget <= 0) begin
                        case (mode)
                            MODE_HBLANK: begin
                                ly = ly + 8'd1;
                                compare_ly();
                                status.hdma_step = 1'b1;
                                enter_mode(ly == VBLANK_LINE ? MODE_VBLANK : MODE_SPRITE);
                            end
                            MODE_VBLANK: begin
                                ly = ly + 8'd1;
                                if (ly == SHORT_LINE) begin
                                    add_budget(int'(SHORT_LINE_CYCLES));
                                    compare_ly();
                                end else if (ly == LINE_END) begin
                                    // LY already reads 0 for the rest of line 153
                                    add_budget(int'(LINE_CYCLES_AFTER_SHORT));
                                    ly = '0;
                                    status.frame_wrap = 1'b1;
                                    compare_ly();
                                end else if (ly == FIRST_LINE) begin
                                    ly = '0;
                                    enter_mode(MODE_SPRITE);
                                end else begin
                                    add_budget(int'(LINE_CYCLES));
                                    compare_ly();
                                end
                            end
                            MODE_SPRITE: begin
                                enter_mode(MODE_TRANSFER);
                            end
                            default: begin
                                enter_mode(MODE_HBLANK);
                            end
                        endcase
                    end
                end
            end
            OP_LCDC: begin
                if (lcd_en && !req.value[LCDC_ON_BIT]) begin
                    ly = '0;
                    mode = MODE_HBLANK;
                end else if (!lcd_en && req.value[LCDC_ON_BIT]) begin
                    budget = 0;
                    mode = MODE_TRANSFER;
                    compare_ly();
                end
                lcd_en = req.value[LCDC_ON_BIT];
            end
            OP_LYC: begin
                lyc = req.value;
            end
            default: begin
                stat_en = req.value[6:3];
            end
        endcase
        status.line = ly;
        status.mode = mode;
        status.coincidence = coinc;
        status.lcd_on = lcd_en;
        return status;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lcd_en = 1'b0;
            ly = '0;
            mode = MODE_HBLANK;
            coinc = 1'b0;
            lyc = '0;
            stat_en = '0;
            budget = 0;
            status_due.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            wraps = 0;
            stat_irqs = 0;
        end else begin
            if (s_valid && s_ready) begin
                status_due.push_back(predict_status(s_data));
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              checked));
                end else begin
                    want = status_due.pop_front();
                    check_field("line", m_data.line, want.line);
                    check_field("mode", m_data.mode, want.mode);
                    check_field("coincidence", m_data.coincidence, want.coincidence);
                    check_field("lcd_on", m_data.lcd_on, want.lcd_on);
                    check_field("stat_irq", m_data.stat_irq, want.stat_irq);
                    check_field("vblank_irq", m_data.vblank_irq, want.vblank_irq);
                    check_field("draw_line", m_data.draw_line, want.draw_line);
                    check_field("hdma_step", m_data.hdma_step, want.hdma_step);
                    check_field("frame_wrap", m_data.frame_wrap, want.frame_wrap);
                    if (want.frame_wrap) wraps++;
                    if (want.stat_irq) stat_irqs++;
                end
                checked++;
            end
            pending = status_due.size();
        end
    end

endmodule

/* verif/lcd_scanline_mode_timer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD scanline mode timer testbench
// Drives directed requests for display on/off, compare and enable writes and
// budget corner cases, then long runs of advances through whole frames with
// occasional register writes, then unconstrained noise. Both channels stall
// at random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_tb;
    import lsmt_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int WELL_FORMED_ITEMS = 760;
    localparam int NOISE_ITEMS       = 120;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lsmt_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lsmt_out_t m_data;

    int errors;
    int pending;
    int checked;
    int wraps;
    int stat_irqs;

    int cycle_count = 0;
    bit calm = 1'b0;
    bit display_on = 1'b0;
    int sent_by_op[4] = '{0, 0, 0, 0};

    always #5 aclk = ~aclk;

    lcd_scanline_mode_timer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    lcd_timing_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .wraps     (wraps),
        .stat_irqs (stat_irqs)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    task automatic send_request(lsmt_op_t op, logic [7:0] cycles, logic [7:0] value);
        lsmt_in_t req;
        req.op = op;
        req.cycles = cycles;
        req.value = value;
        if (!calm && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 14);
        end
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_by_op[op]++;
        if (op == OP_LCDC) display_on = value[LCDC_ON_BIT];
    endtask

    initial begin
        int         pick;
        int         noise_sent;
        logic [7:0] cyc;
        logic [7:0] val;
        lsmt_op_t   op;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: display off, on/off transitions, zero-length advances
        send_request(OP_ADVANCE, 8'd255, 8'h00);
        send_request(OP_STAT, 8'h00, 8'hff);
        send_request(OP_LYC, 8'h00, 8'd0);
        send_request(OP_LCDC, 8'h00, 8'h80);
        send_request(OP_LCDC, 8'h00, 8'hff);
        send_request(OP_ADVANCE, 8'd0, 8'h00);
        send_request(OP_ADVANCE, 8'd255, 8'h00);
        send_request(OP_ADVANCE, 8'd0, 8'h00);
        send_request(OP_LYC, 8'h00, 8'd1);
        send_request(OP_ADVANCE, 8'd255, 8'h00);
        send_request(OP_ADVANCE, 8'd255, 8'h00);
        send_request(OP_ADVANCE, 8'd255, 8'h00);
        send_request(OP_STAT, 8'hff, 8'h00);
        send_request(OP_LCDC, 8'h00, 8'h7f);
        send_request(OP_ADVANCE, 8'd128, 8'hff);
        send_request(OP_LCDC, 8'h00, 8'h80);
        send_request(OP_STAT, 8'h00, 8'h78);
        send_request(OP_LYC, 8'h00, 8'd153);
        send_request(OP_ADVANCE, 8'd1, 8'h00);
        send_request(OP_ADVANCE, 8'd2, 8'h00);
        send_request(OP_ADVANCE, 8'd4, 8'h00);
        send_request(OP_ADVANCE, 8'd8, 8'h00);
        send_request(OP_ADVANCE, 8'd16, 8'h00);
        send_request(OP_ADVANCE, 8'd32, 8'h00);
        send_request(OP_ADVANCE, 8'd64, 8'h00);

        // frames: mostly advances, display kept on
        for (int i = 0; i < WELL_FORMED_ITEMS; i++) begin
            calm = (i >= 300 && i < 500);
            pick = $urandom_range(0, 99);
            if (pick < 94) begin
                if ($urandom_range(0, 3) != 0) cyc = 8'($urandom_range(192, 255));
                else cyc = 8'($urandom_range(0, 255));
                send_request(OP_ADVANCE, cyc, 8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                if ($urandom_range(0, 7) == 0) val = 8'($urandom_range(154, 255));
                else val = 8'($urandom_range(0, 153));
                send_request(OP_LYC, 8'($urandom_range(0, 255)), val);
            end else if (pick < 98) begin
                send_request(OP_STAT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                val = 8'($urandom_range(0, 255));
                val[LCDC_ON_BIT] = 1'b1;
                send_request(OP_LCDC, 8'($urandom_range(0, 255)), val);
            end
        end
        calm = 1'b0;

        // noise: any request, display toggles freely
        noise_sent = 0;
        while (noise_sent < NOISE_ITEMS) begin
            op = lsmt_op_t'($urandom_range(0, 3));
            if (op != OP_ADVANCE || display_on) noise_sent++;
            send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);

        $display("requests sent: %0d advance, %0d lcd control, %0d compare, %0d enable",
                 sent_by_op[OP_ADVANCE], sent_by_op[OP_LCDC], sent_by_op[OP_LYC],
                 sent_by_op[OP_STAT]);
        $display("%0d results checked, %0d frame wraps, %0d status interrupts, %0d mismatches",
                 checked, wraps, stat_irqs, errors);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
